/* hw/rtl/assert_macros.svh */
// Assertion macros shared by the RTL that checks itself.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, disabled during reset.
`define ASSERT_SAME(label, clk, rst, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, disabled during reset.
`define ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

/* hw/rtl/fwsd_pkg.sv */
// Types, constants and codes shared by the FIR filter with silence detection.
package fwsd_pkg;

  localparam int MAX_TAPS_DEFAULT = 64;
  localparam int SAMPLE_WIDTH = 16;
  localparam int FRAC_BITS = SAMPLE_WIDTH - 1;
  localparam int TAP_COUNT_W = 7;
  localparam int ACC_W = 2 * SAMPLE_WIDTH + TAP_COUNT_W;
  localparam int PADDR_W = 3;
  localparam int PDATA_W = 32;

  localparam logic [TAP_COUNT_W-1:0] TAP_RESET = TAP_COUNT_W'(64);
  localparam logic [PADDR_W-3:0] REG_TAP_COUNT = '0;

  localparam logic signed [ACC_W-1:0] ROUND_HALF = ACC_W'(1 << (FRAC_BITS - 1));
  localparam logic signed [ACC_W-1:0] SAT_HI = ACC_W'((1 << (SAMPLE_WIDTH - 1)) - 1);
  localparam logic signed [ACC_W-1:0] SAT_LO = ~SAT_HI;

  typedef enum logic [1:0] {
    CMD_SAMPLE = 2'd0,
    CMD_COEF   = 2'd1,
    CMD_CLEAR  = 2'd2
  } cmd_t;

  typedef struct packed {
    logic [1:0]                     cmd;
    logic signed [SAMPLE_WIDTH-1:0] sample;
    logic [5:0]                     coef_index;
    logic signed [SAMPLE_WIDTH-1:0] coef_value;
  } in_req_t;

  typedef struct packed {
    logic signed [SAMPLE_WIDTH-1:0] sample_out;
    logic                           quiet;
  } out_res_t;

  typedef struct packed {
    logic start_sample;
    logic coef_write;
    logic start_clear;
    logic sweep_hist;
    logic sweep_coef;
    logic issue;
    logic finish;
  } ctrl_cmd_t;

  typedef struct packed {
    logic sweep_last;
    logic tap_last;
    logic pipe_busy;
    logic out_free;
  } ctrl_status_t;

endpackage

/* hw/rtl/fwsd_ctrl.sv */
// Controller state machine: sequences sweeps, tap reads, drain and result load.
module fwsd_ctrl (
  input  logic                   clk,
  input  logic                   rst,
  input  logic                   in_valid,
  input  logic [1:0]             req_cmd,
  output logic                   in_stall,
  input  fwsd_pkg::ctrl_status_t status,
  output fwsd_pkg::ctrl_cmd_t    cmd
);
  import fwsd_pkg::*;

  typedef enum logic [5:0] {
    ST_INIT   = 6'b000001,
    ST_IDLE   = 6'b000010,
    ST_MAC    = 6'b000100,
    ST_DRAIN  = 6'b001000,
    ST_FINISH = 6'b010000,
    ST_CLEAR  = 6'b100000
  } state_t;

  state_t state;
  state_t state_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_INIT;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    cmd        = '0;
    in_stall   = 1'b1;
    unique case (state)
      ST_INIT: begin
        cmd.sweep_hist = 1'b1;
        cmd.sweep_coef = 1'b1;
        if (status.sweep_last) begin
          state_next = ST_IDLE;
        end
      end
      ST_IDLE: begin
        in_stall = 1'b0;
        if (in_valid) begin
          unique case (req_cmd)
            CMD_SAMPLE: begin
              cmd.start_sample = 1'b1;
              state_next       = ST_MAC;
            end
            CMD_COEF: begin
              cmd.coef_write = 1'b1;
            end
            CMD_CLEAR: begin
              cmd.start_clear = 1'b1;
              state_next      = ST_CLEAR;
            end
            default: begin
              state_next = ST_IDLE;
            end
          endcase
        end
      end
      ST_MAC: begin
        cmd.issue = 1'b1;
        if (status.tap_last) begin
          state_next = ST_DRAIN;
        end
      end
      ST_DRAIN: begin
        if (!status.pipe_busy) begin
          state_next = ST_FINISH;
        end
      end
      ST_FINISH: begin
        if (status.out_free) begin
          cmd.finish = 1'b1;
          state_next = ST_IDLE;
        end
      end
      ST_CLEAR: begin
        cmd.sweep_hist = 1'b1;
        if (status.sweep_last) begin
          state_next = ST_IDLE;
        end
      end
      default: begin
        state_next = ST_IDLE;
      end
    endcase
  end

endmodule

/* hw/rtl/fwsd_datapath.sv */
// Datapath: history and coefficient memories, shared multiply-accumulate, output register.
module fwsd_datapath #(
  parameter int MAX_TAPS = fwsd_pkg::MAX_TAPS_DEFAULT
) (
  input  logic                                clk,
  input  logic                                rst,
  input  logic [fwsd_pkg::TAP_COUNT_W-1:0]    tap_count,
  input  fwsd_pkg::in_req_t                   in_data,
  input  fwsd_pkg::ctrl_cmd_t                 cmd,
  output fwsd_pkg::ctrl_status_t              status,
  input  logic                                out_stall,
  output logic                                out_valid,
  output fwsd_pkg::out_res_t                  out_data
);
  import fwsd_pkg::*;

  localparam int AW = (MAX_TAPS > 1) ? $clog2(MAX_TAPS) : 1;
  localparam logic [AW-1:0] LAST_ADDR = AW'(MAX_TAPS - 1);

  logic signed [SAMPLE_WIDTH-1:0] hist_mem [MAX_TAPS];
  logic signed [SAMPLE_WIDTH-1:0] coef_mem [MAX_TAPS];

  logic [TAP_COUNT_W-1:0]         taps;
  logic [TAP_COUNT_W-1:0]         k;
  logic [TAP_COUNT_W-1:0]         zero_run;
  logic [TAP_COUNT_W-1:0]         zero_run_next;
  logic [TAP_COUNT_W:0]           run_inc;
  logic [AW-1:0]                  wp;
  logic [AW-1:0]                  wp_next;
  logic [AW-1:0]                  slot;
  logic [AW-1:0]                  sweep_addr;
  logic [AW-1:0]                  hist_waddr;
  logic [AW-1:0]                  coef_waddr;
  logic signed [SAMPLE_WIDTH-1:0] hist_wdata;
  logic signed [SAMPLE_WIDTH-1:0] coef_wdata;
  logic signed [SAMPLE_WIDTH-1:0] hist_rdata;
  logic signed [SAMPLE_WIDTH-1:0] coef_rdata;
  logic                           hist_we;
  logic                           coef_we;
  logic                           coef_in_range;
  logic                           sweep_last;
  logic                           rd_valid;
  logic                           prod_valid;
  logic signed [2*SAMPLE_WIDTH-1:0] prod;
  logic signed [ACC_W-1:0]        acc;
  logic signed [ACC_W-1:0]        rnd;
  logic signed [ACC_W-1:0]        shifted;
  logic signed [SAMPLE_WIDTH-1:0] rounded;
  logic                           quiet_q;

  always_comb begin
    priority if (tap_count == '0) begin
      taps = TAP_COUNT_W'(1);
    end else if (32'(tap_count) > MAX_TAPS) begin
      taps = TAP_COUNT_W'(MAX_TAPS);
    end else begin
      taps = tap_count;
    end
  end

  assign run_inc = (TAP_COUNT_W + 1)'(zero_run) + (TAP_COUNT_W + 1)'(1);

  always_comb begin
    if (in_data.sample == '0) begin
      zero_run_next = (run_inc < {1'b0, taps}) ? run_inc[TAP_COUNT_W-1:0] : taps;
    end else begin
      zero_run_next = '0;
    end
  end

  assign wp_next       = (wp == LAST_ADDR) ? '0 : wp + 1'b1;
  assign sweep_last    = (sweep_addr == LAST_ADDR);
  assign coef_in_range = (32'(in_data.coef_index) < MAX_TAPS);

  assign hist_we    = cmd.sweep_hist | cmd.start_sample;
  assign hist_waddr = cmd.sweep_hist ? sweep_addr : wp;
  assign hist_wdata = cmd.sweep_hist ? '0 : in_data.sample;

  assign coef_we    = cmd.sweep_coef | (cmd.coef_write & coef_in_range);
  assign coef_waddr = cmd.sweep_coef ? sweep_addr : AW'(in_data.coef_index);
  assign coef_wdata = cmd.sweep_coef ? '0 : in_data.coef_value;

  always_ff @(posedge clk) begin
    if (hist_we) begin
      hist_mem[hist_waddr] <= hist_wdata;
    end
    hist_rdata <= hist_mem[slot];
  end

  always_ff @(posedge clk) begin
    if (coef_we) begin
      coef_mem[coef_waddr] <= coef_wdata;
    end
    coef_rdata <= coef_mem[AW'(k)];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wp         <= '0;
      sweep_addr <= '0;
      zero_run   <= TAP_RESET;
      k          <= '0;
      rd_valid   <= 1'b0;
      prod_valid <= 1'b0;
      out_valid  <= 1'b0;
    end else begin
      rd_valid   <= cmd.issue;
      prod_valid <= rd_valid;
      if (cmd.sweep_hist) begin
        sweep_addr <= sweep_last ? '0 : sweep_addr + 1'b1;
      end
      if (cmd.start_sample) begin
        wp       <= wp_next;
        zero_run <= zero_run_next;
        k        <= '0;
      end else if (cmd.issue) begin
        k <= k + 1'b1;
      end
      if (cmd.start_clear) begin
        wp       <= '0;
        zero_run <= taps;
      end
      if (cmd.finish) begin
        out_valid <= 1'b1;
      end else if (!out_stall) begin
        out_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    prod <= hist_rdata * coef_rdata;
    if (cmd.start_sample) begin
      slot    <= wp;
      quiet_q <= (zero_run_next >= taps);
      acc     <= '0;
    end else begin
      if (cmd.issue) begin
        slot <= (slot == '0) ? LAST_ADDR : slot - 1'b1;
      end
      if (prod_valid) begin
        acc <= acc + ACC_W'(prod);
      end
    end
    if (cmd.finish) begin
      out_data.sample_out <= rounded;
      out_data.quiet      <= quiet_q;
    end
  end

  always_comb begin
    rnd     = acc + ROUND_HALF;
    shifted = rnd >>> FRAC_BITS;
    priority if (shifted > SAT_HI) begin
      rounded = SAMPLE_WIDTH'(SAT_HI);
    end else if (shifted < SAT_LO) begin
      rounded = SAMPLE_WIDTH'(SAT_LO);
    end else begin
      rounded = SAMPLE_WIDTH'(shifted);
    end
  end

  assign status.sweep_last = sweep_last;
  assign status.tap_last   = (k == taps - 1'b1);
  assign status.pipe_busy  = rd_valid | prod_valid;
  assign status.out_free   = !out_valid || !out_stall;

endmodule

/* hw/rtl/fir_filter_with_silence_detect.sv */
// Direct-form FIR filter over Q1.15 samples with zero-run silence detection.
// For a sample request, tap_count is clamped to 1..MAX_TAPS taps: one shared
// multiplier walks the taps at one per cycle out of the history and coefficient
// memories, then the read and multiply stages drain and the rounded sum is
// loaded into the output register. The next request is accepted in the cycle
// after the load; a result still held in the output register delays the load
// and stalls the input. A coefficient write produces no result and does not
// stall the input; a clear zeroes the history and produces no result. After
// reset the block stalls its input while it zeroes both memories. The output
// register holds a finished result while the next request is accepted.
// tap_count is read over the register port at byte address 0 and should be
// written only while idle.
module fir_filter_with_silence_detect #(
  parameter int MAX_TAPS = fwsd_pkg::MAX_TAPS_DEFAULT
) (
  input  logic                           clk,
  input  logic                           rst,
  input  logic                           psel,
  input  logic                           penable,
  input  logic                           pwrite,
  input  logic [fwsd_pkg::PADDR_W-1:0]   paddr,
  input  logic [fwsd_pkg::PDATA_W-1:0]   pwdata,
  output logic [fwsd_pkg::PDATA_W-1:0]   prdata,
  output logic                           pready,
  input  logic                           in_valid,
  output logic                           in_stall,
  input  fwsd_pkg::in_req_t              in_data,
  output logic                           out_valid,
  input  logic                           out_stall,
  output fwsd_pkg::out_res_t             out_data
);
  import fwsd_pkg::*;

`include "assert_macros.svh"

  logic [TAP_COUNT_W-1:0] tap_count;
  logic                   reg_hit;
  logic                   long_req;
  ctrl_cmd_t              ctrl_cmd;
  ctrl_status_t           ctrl_status;

  assign pready  = 1'b1;
  assign reg_hit = (paddr[PADDR_W-1:2] == REG_TAP_COUNT);
  assign prdata  = reg_hit ? PDATA_W'(tap_count) : '0;

  always_ff @(posedge clk) begin
    if (rst) begin
      tap_count <= TAP_RESET;
    end else if (psel && penable && pwrite && pready && reg_hit) begin
      tap_count <= pwdata[TAP_COUNT_W-1:0];
    end
  end

  fwsd_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (in_valid),
    .req_cmd  (in_data.cmd),
    .in_stall (in_stall),
    .status   (ctrl_status),
    .cmd      (ctrl_cmd)
  );

  fwsd_datapath #(
    .MAX_TAPS (MAX_TAPS)
  ) u_datapath (
    .clk       (clk),
    .rst       (rst),
    .tap_count (tap_count),
    .in_data   (in_data),
    .cmd       (ctrl_cmd),
    .status    (ctrl_status),
    .out_stall (out_stall),
    .out_valid (out_valid),
    .out_data  (out_data)
  );

  assign long_req = in_valid && !in_stall &&
                    (in_data.cmd == CMD_SAMPLE || in_data.cmd == CMD_CLEAR);

  `ASSERT_SAME(a_room, clk, rst, ctrl_cmd.finish, ctrl_status.out_free, "finish with result held")
  `ASSERT_SAME(a_load, clk, rst, $rose(out_valid), $past(ctrl_cmd.finish), "no finish")
  `ASSERT_NEXT(a_busy, clk, rst, long_req, in_stall, "input open after sample or clear")

endmodule

/* dv/fir_output_checker.sv */
// Checker for the FIR filter: predicts each filtered sample and compares it with the result.
module fir_output_checker (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          psel,
  input  logic                          penable,
  input  logic                          pwrite,
  input  logic [fwsd_pkg::PADDR_W-1:0]  paddr,
  input  logic [fwsd_pkg::PDATA_W-1:0]  pwdata,
  input  logic                          pready,
  input  logic                          in_valid,
  input  logic                          in_stall,
  input  fwsd_pkg::in_req_t             in_data,
  input  logic                          out_valid,
  input  logic                          out_stall,
  input  fwsd_pkg::out_res_t            out_data,
  output int                            outstanding,
  output int                            failures
);
  import fwsd_pkg::*;

  localparam int TAPS = MAX_TAPS_DEFAULT;
  localparam logic [PADDR_W-1:0] TAP_COUNT_ADDR = {REG_TAP_COUNT, 2'b00};
  localparam longint OUT_MAX = (longint'(1) <<< (SAMPLE_WIDTH - 1)) - 1;
  localparam longint OUT_MIN = -OUT_MAX - 1;

  logic [TAP_COUNT_W-1:0]         tap_reg;
  logic signed [SAMPLE_WIDTH-1:0] history [TAPS];
  logic signed [SAMPLE_WIDTH-1:0] coefs [TAPS];
  logic [5:0]                     wr_ptr;
  int                             zero_run;
  int                             fail_count = 0;
  out_res_t                       expected_outputs [$];
  out_res_t                       want;

  function automatic int taps_active();
    if (tap_reg == 0) return 1;
    if (tap_reg > TAPS) return TAPS;
    return int'(tap_reg);
  endfunction

  function automatic out_res_t filter_next_output(logic signed [SAMPLE_WIDTH-1:0] x);
    int         t;
    longint     acc;
    longint     rounded;
    logic [5:0] slot;
    out_res_t   res;
    t = taps_active();
    history[wr_ptr] = x;
    if (x != 0) zero_run = 0;
    else zero_run = (zero_run + 1 < t) ? zero_run + 1 : t;
    acc = 0;
    for (int k = 0; k < t; k++) begin
      slot = wr_ptr - 6'(k);
      acc += longint'(coefs[k]) * longint'(history[slot]);
    end
    wr_ptr = wr_ptr + 6'd1;
    rounded = (acc + (longint'(1) <<< (FRAC_BITS - 1))) >>> FRAC_BITS;
    if (rounded > OUT_MAX) rounded = OUT_MAX;
    if (rounded < OUT_MIN) rounded = OUT_MIN;
    res.sample_out = rounded[SAMPLE_WIDTH-1:0];
    res.quiet = (zero_run >= t);
    return res;
  endfunction

  always @(posedge clk) begin
    if (rst) begin
      tap_reg = TAP_RESET;
      foreach (history[i]) history[i] = '0;
      foreach (coefs[i]) coefs[i] = '0;
      wr_ptr = '0;
      zero_run = int'(TAP_RESET);
      expected_outputs.delete();
    end else begin
      if (out_valid && !out_stall) begin
        if (expected_outputs.size() == 0) begin
          if (fail_count < 10)
            $display("unexpected result: sample_out %0d quiet %0b",
                     out_data.sample_out, out_data.quiet);
          fail_count++;
        end else begin
          want = expected_outputs.pop_front();
          if (out_data.sample_out !== want.sample_out || out_data.quiet !== want.quiet) begin
            if (fail_count < 10)
              $display("mismatch: expected sample_out %0d quiet %0b, got %0d %0b",
                       want.sample_out, want.quiet, out_data.sample_out, out_data.quiet);
            fail_count++;
          end
        end
      end
      if (psel && penable && pwrite && pready && paddr == TAP_COUNT_ADDR)
        tap_reg = pwdata[TAP_COUNT_W-1:0];
      if (in_valid && !in_stall) begin
        case (in_data.cmd)
          CMD_SAMPLE: expected_outputs.push_back(filter_next_output(in_data.sample));
          CMD_COEF: coefs[in_data.coef_index] = in_data.coef_value;
          CMD_CLEAR: begin
            foreach (history[i]) history[i] = '0;
            wr_ptr = '0;
            zero_run = taps_active();
          end
          default: ;
        endcase
      end
    end
    outstanding <= expected_outputs.size();
    failures <= fail_count;
  end

endmodule

/* dv/testbench.sv */
// Testbench top: drives requests and tap settings into the FIR filter and gives the verdict.
module testbench;
  import fwsd_pkg::*;

  localparam logic [1:0] CMD_RESERVED = 2'd3;
  localparam int TAPS = MAX_TAPS_DEFAULT;
  localparam int CYCLE_LIMIT = 1_000_000;
  localparam int SETTLE_CYCLES = TAPS + 16;
  localparam int HOLD_CYCLES = 300;
  localparam logic [PADDR_W-1:0] TAP_COUNT_ADDR = {REG_TAP_COUNT, 2'b00};
  localparam logic signed [SAMPLE_WIDTH-1:0] S_MAX = 16'sh7fff;
  localparam logic signed [SAMPLE_WIDTH-1:0] S_MIN = 16'sh8000;

  logic               clk = 1'b0;
  logic               rst = 1'b1;
  logic               psel = 1'b0;
  logic               penable = 1'b0;
  logic               pwrite = 1'b0;
  logic [PADDR_W-1:0] paddr = '0;
  logic [PDATA_W-1:0] pwdata = '0;
  logic [PDATA_W-1:0] prdata;
  logic               pready;
  logic               in_valid = 1'b0;
  logic               in_stall;
  in_req_t            in_data = '0;
  logic               out_valid;
  logic               out_stall = 1'b0;
  out_res_t           out_data;
  int                 outstanding;
  int                 failures;

  int cycle_count = 0;
  int hold_requests = 0;
  int hold_seen = 0;
  int active_taps = TAPS;
  bit calm = 1'b0;

  fir_filter_with_silence_detect dut (.*);
  fir_output_checker watch (.*);

  always #5 clk = ~clk;

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("** fir_filter_with_silence_detect: FAILED **");
      $finish;
    end
  end

  function automatic int idle_length();
    int r;
    r = $urandom_range(0, 99);
    if (r < 55) return 0;
    if (r < 85) return $urandom_range(1, 3);
    if (r < 97) return $urandom_range(4, 12);
    return $urandom_range(30, 80);
  endfunction

  function automatic logic [15:0] pick_sample();
    int r;
    r = $urandom_range(0, 99);
    if (r < 25) return '0;
    if (r < 35) begin
      case ($urandom_range(0, 3))
        0: return S_MAX;
        1: return S_MIN;
        2: return 16'h0001;
        default: return 16'hffff;
      endcase
    end
    return 16'($urandom);
  endfunction

  function automatic logic [15:0] pick_coef();
    int r;
    r = $urandom_range(0, 99);
    if (r < 10) return S_MAX;
    if (r < 20) return S_MIN;
    return 16'($urandom);
  endfunction

  function automatic in_req_t rand_req(logic [1:0] c);
    in_req_t r;
    r.cmd = c;
    r.sample = 16'($urandom);
    r.coef_index = 6'($urandom);
    r.coef_value = 16'($urandom);
    return r;
  endfunction

  // Receiver: random stalls, plus one long hold when requested.
  initial begin
    int stall_left;
    int run_left;
    stall_left = 0;
    run_left = 0;
    forever begin
      @(posedge clk);
      if (hold_requests != hold_seen) begin
        hold_seen = hold_requests;
        stall_left = HOLD_CYCLES;
        run_left = 0;
      end
      if (stall_left > 0) begin
        out_stall <= 1'b1;
        stall_left--;
      end else if (run_left > 0) begin
        out_stall <= 1'b0;
        run_left--;
      end else begin
        out_stall <= 1'b0;
        run_left = $urandom_range(0, 24);
        stall_left = calm ? 0 : idle_length();
      end
    end
  end

  task automatic send_req(in_req_t req);
    int gap;
    in_valid <= 1'b1;
    in_data <= req;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    gap = calm ? 0 : idle_length();
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
  endtask

  task automatic send_sample(logic [15:0] x);
    in_req_t r;
    r = rand_req(CMD_SAMPLE);
    r.sample = x;
    send_req(r);
  endtask

  task automatic send_coef(logic [5:0] idx, logic [15:0] v);
    in_req_t r;
    r = rand_req(CMD_COEF);
    r.coef_index = idx;
    r.coef_value = v;
    send_req(r);
  endtask

  task automatic send_cmd(logic [1:0] c);
    send_req(rand_req(c));
  endtask

  // Hold the sender until every result is back and the block has gone quiet.
  task automatic settle();
    in_valid <= 1'b0;
    @(posedge clk);
    while (outstanding != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic write_taps(int value);
    psel <= 1'b1;
    penable <= 1'b0;
    pwrite <= 1'b1;
    paddr <= TAP_COUNT_ADDR;
    pwdata <= PDATA_W'(value);
    @(posedge clk);
    penable <= 1'b1;
    @(posedge clk);
    while (!pready) @(posedge clk);
    psel <= 1'b0;
    penable <= 1'b0;
    pwrite <= 1'b0;
    active_taps = (value == 0) ? 1 : (value > TAPS) ? TAPS : value;
  endtask

  task automatic run_random(int n);
    int done;
    int r;
    int burst;
    done = 0;
    while (done < n) begin
      r = $urandom_range(0, 99);
      if (r < 5) begin
        send_cmd(CMD_CLEAR);
      end else if (r < 20) begin
        send_coef(6'($urandom), pick_coef());
      end else if (r < 22) begin
        send_cmd(CMD_RESERVED);
        continue;
      end else if (r < 27) begin
        burst = active_taps + $urandom_range(0, 3);
        repeat (burst) send_sample('0);
        done += burst - 1;
      end else begin
        send_sample(pick_sample());
      end
      done++;
    end
  endtask

  initial begin
    int tap_plan[8];
    tap_plan = '{1, 0, 127, 2, 64, 65, 0, 5};
    tap_plan[6] = $urandom_range(3, 63);
    repeat (4) @(posedge clk);
    rst <= 1'b0;

    send_sample('0);
    send_coef(6'd0, S_MAX);
    send_coef(6'd63, S_MIN);
    send_coef(6'd1, S_MIN);
    send_sample(S_MAX);
    send_sample(S_MIN);
    send_sample(16'h0001);
    send_sample(16'hffff);
    send_sample('0);
    send_cmd(CMD_RESERVED);
    send_cmd(CMD_CLEAR);
    send_sample('0);
    send_sample(S_MIN);
    send_sample(S_MIN);
    send_coef(6'd1, S_MAX);
    send_sample(S_MAX);
    send_sample(S_MAX);
    send_coef(6'd2, 16'h4000);
    send_coef(6'd3, 16'h0001);
    send_sample(16'($urandom));
    send_sample(S_MIN);
    settle();

    foreach (tap_plan[i]) begin
      calm = (i == 1 || i == 4);
      write_taps(tap_plan[i]);
      if (i == 2) hold_requests++;
      run_random(100);
      settle();
    end

    if (failures == 0) begin
      $display("** fir_filter_with_silence_detect: PASSED **");
    end else begin
      $display("** fir_filter_with_silence_detect: FAILED **");
    end
    $finish;
  end

endmodule
